[rtl/core/kpst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kpst_pkg;

    // Default number of key entries in the state memory.
    localparam int KEY_COUNT_DEF = 256;

    // Width of the key code field.
    localparam int CODE_W = 8;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_PTR   = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    // Per-key state codes.
    typedef enum logic [1:0] {
        KS_UP       = 2'd0,
        KS_DOWN     = 2'd1,
        KS_PRESSED  = 2'd2,
        KS_RELEASED = 2'd3
    } key_state_t;

    // Command handed from the top level to the key sequencer.
    typedef struct packed {
        kind_t             kind;
        logic [CODE_W-1:0] key_code;
        key_state_t        new_key_state;
    } key_cmd_t;

    // Status returned by the key sequencer when an item is finished.
    typedef struct packed {
        logic done;
        logic is_down;
        logic is_pressed;
        logic is_released;
    } key_stat_t;

    // Frame aging: pressed settles to down, released settles to up.
    function automatic key_state_t age_state(input key_state_t st);
        key_state_t res;
        case (st)
            KS_PRESSED:  res = KS_DOWN;
            KS_RELEASED: res = KS_UP;
            default:     res = st;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/kpst_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input item channel.
interface kpst_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         key_code;
    logic [1:0]         new_key_state;
    logic signed [15:0] pointer_x_in;
    logic signed [15:0] pointer_y_in;

    modport source (
        output valid, kind, key_code, new_key_state, pointer_x_in, pointer_y_in,
        input  ready
    );
    modport sink (
        input  valid, kind, key_code, new_key_state, pointer_x_in, pointer_y_in,
        output ready
    );
endinterface

// Status result channel.
interface kpst_out_if;
    logic               valid;
    logic               ready;
    logic               is_down;
    logic               is_pressed;
    logic               is_released;
    logic signed [16:0] delta_x;
    logic signed [16:0] delta_y;

    modport source (
        output valid, is_down, is_pressed, is_released, delta_x, delta_y,
        input  ready
    );
    modport sink (
        input  valid, is_down, is_pressed, is_released, delta_x, delta_y,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/kpst_key_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module kpst_key_mem
    import kpst_pkg::*;
#(
    parameter int DEPTH = KEY_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic       clk,
    input  wire logic       wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire key_state_t wr_data,
    input  wire logic       rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output key_state_t      rd_data
);

    key_state_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/kpst_key_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module kpst_key_seq
    import kpst_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire key_cmd_t cmd,
    input  wire logic     out_free,
    output logic          idle,
    output key_stat_t     stat
);

    localparam int AW    = $clog2(KEY_COUNT);
    localparam int CNT_W = $clog2(KEY_COUNT + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_KEY_WR,
        S_SWEEP,
        S_LOOK,
        S_WAIT
    } seq_state_t;

    seq_state_t        state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              pend_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic [CODE_W-1:0] code_reg;
    key_state_t        nst_reg;
    logic              valid_reg;

    logic              cmd_valid;
    logic              sweep_issue;
    logic [AW-1:0]     code_addr;

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    key_state_t        mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    key_state_t        mem_rd_data;

    // Only codes 1 to KEY_COUNT-1 address a key.
    assign cmd_valid = (cmd.key_code != '0) && (32'(cmd.key_code) < 32'(KEY_COUNT));
    assign code_addr = AW'(code_reg);

    // The sweep issues one read per cycle until the last key.
    assign sweep_issue = (state_reg == S_SWEEP) && (cnt_reg < CNT_W'(KEY_COUNT));

    // Sequencer state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(KEY_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        unique case (cmd.kind)
                            KIND_KEY:
                            begin
                                state_reg <= S_KEY_WR;
                            end
                            KIND_TICK:
                            begin
                                cnt_reg   <= CNT_W'(1);
                                state_reg <= S_SWEEP;
                            end
                            default:
                            begin
                                state_reg <= S_LOOK;
                            end
                        endcase
                    end
                end
                S_KEY_WR:
                begin
                    state_reg <= S_LOOK;
                end
                S_SWEEP:
                begin
                    pend_reg <= sweep_issue;
                    if (sweep_issue)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    else if (!pend_reg)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                    cnt_reg   <= '0;
                end
            endcase
        end
    end

    // Captured command fields and the sweep write-back address.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            code_reg  <= cmd.key_code;
            nst_reg   <= cmd.new_key_state;
            valid_reg <= cmd_valid;
        end
        pend_addr_reg <= cnt_reg[AW-1:0];
    end

    // Memory port steering: clear, key write, sweep read/age/write, lookup.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = KS_UP;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_reg[AW-1:0];
            end
            S_KEY_WR:
            begin
                mem_wr_en   = valid_reg;
                mem_wr_addr = code_addr;
                mem_wr_data = nst_reg;
            end
            S_SWEEP:
            begin
                mem_rd_en   = sweep_issue;
                mem_rd_addr = cnt_reg[AW-1:0];
                mem_wr_en   = pend_reg;
                mem_wr_addr = pend_addr_reg;
                mem_wr_data = age_state(mem_rd_data);
            end
            S_LOOK:
            begin
                mem_rd_en   = valid_reg;
                mem_rd_addr = code_addr;
            end
            default:
            begin
            end
        endcase
    end

    kpst_key_mem #(
        .DEPTH (KEY_COUNT),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Status toward the output register.
    assign idle             = (state_reg == S_IDLE);
    assign stat.done        = (state_reg == S_WAIT) && out_free;
    assign stat.is_down     = valid_reg && (mem_rd_data == KS_DOWN);
    assign stat.is_pressed  = valid_reg && (mem_rd_data == KS_PRESSED);
    assign stat.is_released = valid_reg && (mem_rd_data == KS_RELEASED);

endmodule

`default_nettype wire

[rtl/core/key_and_pointer_state_tracker.sv]
// Key and pointer state tracker.
// Input transactions arrive on the item channel (kind, key_code, new_key_state,
// pointer position); every accepted transaction yields exactly one status
// transaction on the status channel with the flags of key_code and the
// pointer delta, both taken after the item has been applied.
// Key states live in a KEY_COUNT-entry memory with one write and one
// registered read port, driven by a small sequencer. The block takes one item
// at a time and holds item.ready low while it works.
// Before the lookup, a key event writes its new state and a frame tick
// sweeps the memory, reading and writing back one key per cycle through the
// memory ports; a pointer event or a query goes straight to the lookup.
// item.ready rises as the status is loaded into the output register.
// After reset the sequencer clears the key memory, one entry per cycle, and
// holds item.ready low until the clear is done; pointer positions
// reset to zero at once.
// The status sits in an output register. A new item is accepted while an
// earlier status still waits; a stalled receiver holds the next item in its
// last step until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module key_and_pointer_state_tracker
    import kpst_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kpst_in_if.sink    item,
    kpst_out_if.source status
);

    logic               seq_idle;
    logic               accept;
    logic               out_free;
    key_cmd_t           cmd;
    key_stat_t          stat;

    logic signed [15:0] cur_x_reg;
    logic signed [15:0] cur_y_reg;
    logic signed [15:0] prev_x_reg;
    logic signed [15:0] prev_y_reg;

    logic               out_vld_reg;
    logic               is_down_reg;
    logic               is_pressed_reg;
    logic               is_released_reg;
    logic signed [16:0] delta_x_reg;
    logic signed [16:0] delta_y_reg;

    assign item.ready = seq_idle;
    assign accept     = item.valid && item.ready;

    assign cmd.kind          = kind_t'(item.kind);
    assign cmd.key_code      = item.key_code;
    assign cmd.new_key_state = key_state_t'(item.new_key_state);

    kpst_key_seq #(
        .KEY_COUNT (KEY_COUNT)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .cmd      (cmd),
        .out_free (out_free),
        .idle     (seq_idle),
        .stat     (stat)
    );

    // Pointer positions: an event moves the current one, a tick latches it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        else if (accept)
        begin
            if (item.kind == KIND_PTR)
            begin
                cur_x_reg <= item.pointer_x_in;
                cur_y_reg <= item.pointer_y_in;
            end
            if (item.kind == KIND_TICK)
            begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
            end
        end
    end

    // Output register valid flag.
    assign out_free = !out_vld_reg || status.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Output payload: key flags and sign-extended pointer differences.
    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            is_down_reg     <= stat.is_down;
            is_pressed_reg  <= stat.is_pressed;
            is_released_reg <= stat.is_released;
            delta_x_reg     <= {cur_x_reg[15], cur_x_reg} - {prev_x_reg[15], prev_x_reg};
            delta_y_reg     <= {cur_y_reg[15], cur_y_reg} - {prev_y_reg[15], prev_y_reg};
        end
    end

    assign status.valid       = out_vld_reg;
    assign status.is_down     = is_down_reg;
    assign status.is_pressed  = is_pressed_reg;
    assign status.is_released = is_released_reg;
    assign status.delta_x     = delta_x_reg;
    assign status.delta_y     = delta_y_reg;

    // The sequencer leaves idle right after a transaction is accepted.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item.ready)
        else $error("item channel still ready after an accepted transaction");

    // A frame tick makes the previous position equal the current one.
    a_tick_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.kind == KIND_TICK)) |=>
            ((prev_x_reg == cur_x_reg) && (prev_y_reg == cur_y_reg)))
        else $error("frame tick did not latch the pointer position");

    // A status is produced only while an item is in flight.
    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !item.ready)
        else $error("status produced while the sequencer is idle");

    // A key holds exactly one state, so at most one flag is set.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid |-> $onehot0({status.is_down, status.is_pressed, status.is_released}))
        else $error("more than one key flag set");

endmodule

`default_nettype wire

[bench/tb_key_and_pointer_state_tracker.sv]
`timescale 1ns / 1ps

module tb_key_and_pointer_state_tracker;

    import kpst_pkg::*;

    localparam int KEY_COUNT = KEY_COUNT_DEF;

    // Status fields as the tracker reports them.
    typedef struct {
        logic               is_down;
        logic               is_pressed;
        logic               is_released;
        logic signed [16:0] delta_x;
        logic signed [16:0] delta_y;
    } status_t;

    logic clk = 1'b0;
    logic rst_n;

    kpst_in_if  item_ch ();
    kpst_out_if stat_ch ();

    key_and_pointer_state_tracker #(
        .KEY_COUNT(KEY_COUNT)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .status(stat_ch)
    );

    // Mirror of the tracker state.
    key_state_t         key_mem [KEY_COUNT];
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;

    // Status transactions still owed by the block, oldest first.
    status_t status_due [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int unexpected_count;

    always #4 clk = ~clk;

    // Applies one item to the mirrored state and returns the status it yields.
    function automatic status_t step_tracker(input kind_t k, input logic [7:0] code,
                                             input key_state_t nst,
                                             input logic signed [15:0] px,
                                             input logic signed [15:0] py);
        status_t    res;
        key_state_t st;
        bit         code_ok;
        code_ok = (code != 8'd0) && (int'(code) < KEY_COUNT);
        case (k)
            KIND_KEY:
            begin
                if (code_ok)
                    key_mem[code] = nst;
            end
            KIND_PTR:
            begin
                cur_x = px;
                cur_y = py;
            end
            KIND_TICK:
            begin
                // Pressed settles to down and released to up on every valid key.
                for (int i = 1; i < KEY_COUNT; i++)
                begin
                    if (key_mem[i] == KS_PRESSED)
                        key_mem[i] = KS_DOWN;
                    else if (key_mem[i] == KS_RELEASED)
                        key_mem[i] = KS_UP;
                end
                prev_x = cur_x;
                prev_y = cur_y;
            end
            default:
            begin
            end
        endcase
        st = code_ok ? key_mem[code] : KS_UP;
        res.is_down     = (st == KS_DOWN);
        res.is_pressed  = (st == KS_PRESSED);
        res.is_released = (st == KS_RELEASED);
        res.delta_x     = {cur_x[15], cur_x} - {prev_x[15], prev_x};
        res.delta_y     = {cur_y[15], cur_y} - {prev_y[15], prev_y};
        return res;
    endfunction

    // Presents one item, waits for its acceptance and records the status it owes.
    task automatic send_item(input kind_t k, input logic [7:0] code, input key_state_t nst,
                             input logic signed [15:0] px, input logic signed [15:0] py);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.kind          <= k;
        item_ch.key_code      <= code;
        item_ch.new_key_state <= nst;
        item_ch.pointer_x_in  <= px;
        item_ch.pointer_y_in  <= py;
        do
            @(posedge clk);
        while (!item_ch.ready);
        status_due.push_back(step_tracker(k, code, nst, px, py));
    endtask

    // Stops sending until every owed status transaction has arrived.
    task automatic hold_until_drained();
        item_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Receiver: stalls at random while the current idle rate asks for it.
    initial
    begin
        stat_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            stat_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare every accepted status transaction with the oldest one owed.
    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && stat_ch.valid && stat_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("[%0t] status transaction with none outstanding", $realtime);
            end
            else
            begin
                want = status_due.pop_front();
                if (stat_ch.is_down !== want.is_down || stat_ch.is_pressed !== want.is_pressed
                    || stat_ch.is_released !== want.is_released
                    || stat_ch.delta_x !== want.delta_x || stat_ch.delta_y !== want.delta_y)
                begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display({"[%0t] status mismatch: expected down=%0b pressed=%0b ",
                                  "released=%0b dx=%0d dy=%0d, got down=%0b pressed=%0b ",
                                  "released=%0b dx=%0d dy=%0d"},
                                 $realtime, want.is_down, want.is_pressed, want.is_released,
                                 want.delta_x, want.delta_y, stat_ch.is_down,
                                 stat_ch.is_pressed, stat_ch.is_released, stat_ch.delta_x,
                                 stat_ch.delta_y);
                end
            end
        end
    end

    // Right after reset every key is up and the pointer delta is zero.
    task automatic test_reset_state();
        send_item(KIND_QUERY, 8'd1, KS_UP, 16'sd0, 16'sd0);
        send_item(KIND_QUERY, 8'd255, KS_UP, 16'sd0, 16'sd0);
        send_item(KIND_QUERY, 8'd0, KS_UP, 16'sd0, 16'sd0);
    endtask

    // Key events on the lowest and highest valid codes, every state, and the
    // invalid code zero, which must change nothing and always report no flags.
    task automatic test_key_events();
        send_item(KIND_KEY, 8'd1, KS_PRESSED, 16'sd0, 16'sd0);
        send_item(KIND_KEY, 8'd255, KS_RELEASED, 16'sd0, 16'sd0);
        send_item(KIND_KEY, 8'd128, KS_DOWN, 16'sd0, 16'sd0);
        send_item(KIND_KEY, 8'd0, KS_PRESSED, 16'sd0, 16'sd0);
        send_item(KIND_QUERY, 8'd0, KS_DOWN, 16'sd0, 16'sd0);
        send_item(KIND_KEY, 8'd64, KS_DOWN, 16'sd0, 16'sd0);
        send_item(KIND_KEY, 8'd64, KS_UP, 16'sd0, 16'sd0);
        send_item(KIND_QUERY, 8'd1, KS_UP, 16'sd0, 16'sd0);
        send_item(KIND_QUERY, 8'd255, KS_UP, 16'sd0, 16'sd0);
        send_item(KIND_QUERY, 8'd64, KS_UP, 16'sd0, 16'sd0);
    endtask

    // Pointer extremes give the largest deltas in both directions; a tick
    // zeroes the delta in its own status.
    task automatic test_pointer_extremes();
        send_item(KIND_PTR, 8'd128, KS_UP, 16'sh7fff, -16'sh8000);
        send_item(KIND_TICK, 8'd200, KS_UP, 16'sd0, 16'sd0);
        send_item(KIND_PTR, 8'd1, KS_UP, -16'sh8000, 16'sh7fff);
        send_item(KIND_PTR, 8'd0, KS_UP, 16'sd0, 16'sd0);
    endtask

    // A tick ages pressed and released keys, including the highest code,
    // and leaves down keys alone.
    task automatic test_frame_tick();
        send_item(KIND_KEY, 8'd1, KS_PRESSED, 16'sd0, 16'sd0);
        send_item(KIND_KEY, 8'd255, KS_RELEASED, 16'sd0, 16'sd0);
        send_item(KIND_TICK, 8'd1, KS_UP, 16'sd0, 16'sd0);
        send_item(KIND_QUERY, 8'd255, KS_UP, 16'sd0, 16'sd0);
        send_item(KIND_QUERY, 8'd128, KS_UP, 16'sd0, 16'sd0);
        send_item(KIND_TICK, 8'd0, KS_UP, 16'sd0, 16'sd0);
    endtask

    // Random traffic focused on a few keys so that events, ticks and queries
    // interact; a share of codes spans the whole field, zero included.
    task automatic test_random_traffic(input int n);
        int         r;
        kind_t      k;
        logic [7:0] code;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 35)
                k = KIND_KEY;
            else if (r < 65)
                k = KIND_QUERY;
            else if (r < 85)
                k = KIND_PTR;
            else
                k = KIND_TICK;
            r = $urandom_range(99);
            if (r < 8)
                code = 8'd0;
            else if (r < 60)
                code = 8'($urandom_range(6, 1));
            else if (r < 68)
                code = 8'd255;
            else
                code = 8'($urandom_range(255));
            send_item(k, code, key_state_t'($urandom_range(3)), 16'($urandom),
                      16'($urandom));
        end
    endtask

    initial
    begin
        mismatch_count   = 0;
        unexpected_count = 0;
        send_idle_pct    = 33;
        recv_idle_pct    = 49;
        for (int i = 0; i < KEY_COUNT; i++)
            key_mem[i] = KS_UP;
        cur_x  = '0;
        cur_y  = '0;
        prev_x = '0;
        prev_y = '0;

        rst_n                 <= 1'b0;
        item_ch.valid         <= 1'b0;
        item_ch.kind          <= KIND_QUERY;
        item_ch.key_code      <= '0;
        item_ch.new_key_state <= KS_UP;
        item_ch.pointer_x_in  <= '0;
        item_ch.pointer_y_in  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_key_events();
        test_pointer_extremes();
        test_frame_tick();
        test_random_traffic(130);

        // Swap the idle rates of sender and receiver.
        send_idle_pct = 49;
        recv_idle_pct = 33;
        test_random_traffic(130);
        hold_until_drained();

        // Full throughput on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(140);

        hold_until_drained();
        repeat (KEY_COUNT + 8) @(posedge clk);
        if (mismatch_count == 0 && unexpected_count == 0 && status_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
